>>> rtl/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg: shared types and constants for the interrupt slot balancer
// Bucket count, counter width, operation codes, the scan token and the
// control / status bundles between the top level and the bucket cells.
// ----------------------------------------------------------------------------
package isb_pkg;

   localparam int NUM_BUCKETS = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(NUM_BUCKETS);

   localparam int OP_W       = 1;
   localparam int INTERVAL_W = 8;
   localparam int REL_W      = 6;
   localparam int BUCKET_W   = 6;
   localparam int LOAD_W     = 16;

   localparam logic [OP_W-1:0] OP_OPEN  = 1'b0;
   localparam logic [OP_W-1:0] OP_CLOSE = 1'b1;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   // half the bucket count, the cap on the polling interval
   localparam logic [INTERVAL_W:0] HALF_BUCKETS = (INTERVAL_W+1)'(NUM_BUCKETS / 2);

   // scan token handed from cell to cell: running minimum and its bucket
   typedef struct packed {
      logic      v;
      count_type val;
      idx_type   idx;
   } tok_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic            inject;
      logic            scan;
      logic            update;
      logic            collect;
      logic [OP_W-1:0] op;
      idx_type         base;
      idx_type         last;
      idx_type         target;
   } ctrl_type;

   // per-cell status back to the controller
   typedef struct packed {
      logic      done;
      idx_type   best_idx;
      logic      hit;
      count_type count;
      logic      clamp;
   } cell_stat_type;

   // largest power of two not above min(interval, NUM_BUCKETS/2); 0 for 0
   function automatic idx_type span_base(input logic [INTERVAL_W-1:0] interval);
      logic [INTERVAL_W:0] lim;
      idx_type             b;
      lim = ({1'b0, interval} > HALF_BUCKETS) ? HALF_BUCKETS : {1'b0, interval};
      b   = '0;
      for (int k = 0; k <= INTERVAL_W; k++) begin
         if (lim[k]) begin
            b = IDX_W'((INTERVAL_W+1)'(1) << k);
         end
      end
      return b;
   endfunction

endpackage

>>> rtl/interrupt_slot_balancer.sv
// ----------------------------------------------------------------------------
// interrupt_slot_balancer: least-loaded bucket placement for a polling tree
// A row of bucket cells with a scan token and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beat: operation (open/close), poll_interval, release_bucket.
//   rsp_* beat: bucket, bucket_load (count after update), count_clamped.
//   One rsp beat per req beat, in order.
//   An open with base B (power of two from the interval, capped at half the
//   bucket count) sends a token from cell B to cell 2B-1, one cell a cycle;
//   then an update step and a collect step follow.
//   req_ready is high only while the sequencer is idle; a new request is
//   taken while the previous response still waits on rsp_ready, and the
//   sequencer holds in its collect step until the response register frees.
//   Synchronous reset clears all counts to zero and drops rsp_valid.
// ----------------------------------------------------------------------------
module interrupt_slot_balancer import isb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [INTERVAL_W-1:0] req_poll_interval,
   input  logic [REL_W-1:0]      req_release_bucket,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BUCKET_W-1:0]   rsp_bucket,
   output logic [LOAD_W-1:0]     rsp_bucket_load,
   output logic                  rsp_count_clamped
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_UPDATE  = 2'd2;
   localparam logic [1:0] ST_COLLECT = 2'd3;

   localparam logic [REL_W+8:0] NUM_BUCKETS_W = (REL_W+9)'(NUM_BUCKETS);

   logic [1:0]          st_ff, st_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [REL_W-1:0]    rel_ff, rel_in;
   idx_type             base_ff, base_in;
   idx_type             last_ff, last_in;
   idx_type             target_ff, target_in;
   logic                inject_ff, inject_in;
   logic                upd_en_ff, upd_en_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [LOAD_W-1:0]   rsp_load_ff, rsp_load_in;
   logic                rsp_clamp_ff, rsp_clamp_in;

   ctrl_type      ctrl;
   tok_type       toks  [NUM_BUCKETS];
   tok_type       prevs [NUM_BUCKETS];
   cell_stat_type stats [NUM_BUCKETS];

   logic [NUM_BUCKETS-1:0] done_vec, hit_vec, tokv_vec;
   logic      done_any;
   idx_type   best_sel;
   count_type count_sel;
   logic      clamp_sel;
   idx_type   req_base;
   logic      req_acc;

   // ---- cell row ----
   for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prevs[i] = '0;
      end else begin : g_link
         assign prevs[i] = toks[i-1];
      end
      isb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_idx   (IDX_W'(i)),
         .ctrl     (ctrl),
         .prev_tok (prevs[i]),
         .tok      (toks[i]),
         .stat     (stats[i])
      );
      assign done_vec[i] = stats[i].done;
      assign hit_vec[i]  = stats[i].hit;
      assign tokv_vec[i] = toks[i].v;
   end

   // one-hot gather from the row: at most one done cell, at most one hit cell
   always_comb begin
      done_any  = 1'b0;
      best_sel  = '0;
      count_sel = '0;
      clamp_sel = 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         done_any  = done_any | stats[i].done;
         best_sel  = best_sel | (stats[i].done ? stats[i].best_idx : '0);
         count_sel = count_sel | (stats[i].hit ? stats[i].count : '0);
         clamp_sel = clamp_sel | (stats[i].hit & stats[i].clamp);
      end
   end

   always_comb begin
      ctrl.inject  = inject_ff;
      ctrl.scan    = (st_ff == ST_SCAN);
      ctrl.update  = (st_ff == ST_UPDATE) && upd_en_ff;
      ctrl.collect = (st_ff == ST_COLLECT);
      ctrl.op      = op_ff;
      ctrl.base    = base_ff;
      ctrl.last    = last_ff;
      ctrl.target  = target_ff;
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign req_base  = span_base(req_poll_interval);

   // ---- sequencer ----
   always_comb begin
      st_in         = st_ff;
      op_in         = op_ff;
      rel_in        = rel_ff;
      base_in       = base_ff;
      last_in       = last_ff;
      target_in     = target_ff;
      inject_in     = 1'b0;
      upd_en_in     = upd_en_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_clamp_in  = rsp_clamp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in   = req_operation;
               rel_in  = req_release_bucket;
               base_in = req_base;
               last_in = (req_base << 1) - idx_type'(1);
               if (req_operation == OP_OPEN) begin
                  upd_en_in = 1'b1;
                  target_in = '0;
                  if (req_base == '0) begin
                     st_in = ST_UPDATE;
                  end else begin
                     st_in     = ST_SCAN;
                     inject_in = 1'b1;
                  end
               end else begin
                  // a close beyond the row touches no cell and reports zeros
                  upd_en_in = ({9'd0, req_release_bucket} < NUM_BUCKETS_W);
                  target_in = IDX_W'(req_release_bucket);
                  st_in     = ST_UPDATE;
               end
            end
         end
         ST_SCAN: begin
            if (done_any) begin
               target_in = best_sel;
               st_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            st_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = (op_ff == OP_OPEN) ? BUCKET_W'(target_ff) : rel_ff;
               rsp_load_in   = LOAD_W'(count_sel);
               rsp_clamp_in  = clamp_sel;
               st_in         = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         inject_ff    <= 1'b0;
         upd_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         inject_ff    <= inject_in;
         upd_en_ff    <= upd_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      rel_ff        <= rel_in;
      base_ff       <= base_in;
      last_ff       <= last_in;
      target_ff     <= target_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_load_ff   <= rsp_load_in;
      rsp_clamp_ff  <= rsp_clamp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bucket        = rsp_bucket_ff;
   assign rsp_bucket_load   = rsp_load_ff;
   assign rsp_count_clamped = rsp_clamp_ff;

   // ---- checks ----
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tokv_vec))
      else $error("more than one scan token in the row");

   a_one_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0(done_vec))
      else $error("more than one cell ends the scan");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell updated");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(st_ff) == ST_COLLECT)
      else $error("response raised outside the collect step");

endmodule

>>> rtl/isb_cell.sv
// ----------------------------------------------------------------------------
// isb_cell: one bucket of the balancer
// Holds one use count, takes the scan token from its left neighbor, folds in
// its own count, and applies the increment or decrement when it is targeted.
// ----------------------------------------------------------------------------
module isb_cell import isb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  idx_type       my_idx,
   input  ctrl_type      ctrl,
   input  tok_type       prev_tok,
   output tok_type       tok,
   output cell_stat_type stat
);

   count_type count_ff, count_in;
   tok_type   tok_ff, tok_in;
   logic      hit_ff, hit_in;
   logic      clamp_ff, clamp_in;
   logic      inj, take, match;

   always_comb begin
      inj   = ctrl.inject && (my_idx == ctrl.base);
      // token moves on only while its sender is still short of the last bucket
      take  = ctrl.scan && prev_tok.v && (my_idx <= ctrl.last);
      match = ctrl.update && (my_idx == ctrl.target);

      tok_in = '0;
      if (inj) begin
         tok_in = '{v: 1'b1, val: count_ff, idx: my_idx};
      end else if (take) begin
         if (count_ff < prev_tok.val) begin
            tok_in = '{v: 1'b1, val: count_ff, idx: my_idx};
         end else begin
            tok_in = prev_tok;
         end
      end

      count_in = count_ff;
      clamp_in = clamp_ff;
      hit_in   = ctrl.collect && hit_ff;
      if (match) begin
         hit_in = 1'b1;
         if (ctrl.op == OP_OPEN) begin
            if (count_ff == COUNT_MAX) begin
               clamp_in = 1'b1;
            end else begin
               clamp_in = 1'b0;
               count_in = count_ff + count_type'(1);
            end
         end else begin
            if (count_ff == '0) begin
               clamp_in = 1'b1;
            end else begin
               clamp_in = 1'b0;
               count_in = count_ff - count_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tok_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         tok_ff   <= tok_in;
         hit_ff   <= hit_in;
      end
      clamp_ff <= clamp_in;
   end

   assign tok           = tok_ff;
   assign stat.done     = tok_ff.v && (my_idx == ctrl.last);
   assign stat.best_idx = tok_ff.idx;
   assign stat.hit      = hit_ff;
   assign stat.count    = count_ff;
   assign stat.clamp    = clamp_ff;

endmodule
